@@ rtl/gtd_pkg.sv @@
// ----------------------------------------------------------------------------
// gtd_pkg
// Shared types, constants and helpers of the Goertzel tone detector.
// ----------------------------------------------------------------------------
package gtd_pkg;

  localparam int SAMPLE_BITS_DEF      = 16;
  localparam int MAX_BLOCK_LENGTH_DEF = 4096;
  localparam int QUEUE_DEPTH          = 2;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int LEN_W      = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int VAL_W      = 48;
  localparam int POW_W      = 63;
  localparam int SUM_W      = 51;
  localparam int HALF_W     = 24;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int FRAC_W     = 14;

  localparam logic signed [VAL_W-1:0]  VAL_MAX    = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0]  VAL_MIN    = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [POW_W-1:0]         POWER_MAX  = '1;
  localparam logic [VAL_W-1:0]         ROOT_LIMIT = 48'd3037000499;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

  localparam logic signed [COEF_W-1:0] COEF_RESET   = 16'sd0;
  localparam logic signed [COEF_W-1:0] COSINE_RESET = 16'sd16384;
  localparam logic signed [COEF_W-1:0] SINE_RESET   = 16'sd0;
  localparam logic [LEN_W-1:0]         LEN_RESET    = 13'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF      = 4'd0,
    CFG_COSINE    = 4'd1,
    CFG_SINE      = 4'd2,
    CFG_BLOCK_LEN = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic signed [COEF_W-1:0] cosine;
    logic signed [COEF_W-1:0] sine;
    logic [LEN_W-1:0]         blk_len;
  } cfg_t;

  typedef struct packed {
    logic                    sat;
    logic signed [VAL_W-1:0] val;
  } clamp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RHI,
    ST_RLO,
    ST_RSUM,
    ST_RUPD,
    ST_CHI,
    ST_CLO,
    ST_CSUM,
    ST_SLO,
    ST_SSUM,
    ST_IMAG,
    ST_MAG,
    ST_SQR_R,
    ST_SQR_I,
    ST_PSUM,
    ST_EMIT
  } back_state_e;

  function automatic clamp_t clamp_val(input logic signed [SUM_W-1:0] x);
    clamp_t r;
    if (x > SUM_W'(VAL_MAX)) begin
      r.sat = 1'b1;
      r.val = VAL_MAX;
    end else if (x < SUM_W'(VAL_MIN)) begin
      r.sat = 1'b1;
      r.val = VAL_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = x[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/gtd_front.sv @@
// ----------------------------------------------------------------------------
// gtd_front
// Accepts samples, counts them against the block length and tags the last
// sample of each block before handing the item to the queue.
// ----------------------------------------------------------------------------
module gtd_front #(
  parameter int SAMPLE_BITS      = gtd_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_BLOCK_LENGTH = gtd_pkg::MAX_BLOCK_LENGTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [gtd_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic [gtd_pkg::LEN_W-1:0]           block_length_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output logic [SAMPLE_BITS:0]                push_data_o
);
  import gtd_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK_LENGTH + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int RAW_W = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [CMP_W-1:0] MaxLen = CMP_W'(MAX_BLOCK_LENGTH);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CMP_W-1:0] cnt_x, cnt_inc, bl_x, len_eff;
  logic [RAW_W-1:0] raw;
  logic             last;
  logic             accept;

  assign in_stall_o   = !push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  always_comb begin
    cnt_x   = CMP_W'(cnt_q);
    bl_x    = CMP_W'(block_length_i);
    cnt_inc = (cnt_x < MaxLen) ? cnt_x + CMP_W'(1) : cnt_x;
    if (bl_x == '0) begin
      len_eff = CMP_W'(1);
    end else if (bl_x > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = bl_x;
    end
    last  = (cnt_inc >= len_eff);
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = last ? '0 : CNT_W'(cnt_inc);
    end
    raw         = RAW_W'($unsigned(sample_value_i));
    push_data_o = {last, raw[SAMPLE_BITS-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/gtd_queue.sv @@
// ----------------------------------------------------------------------------
// gtd_queue
// Short register queue that decouples sample intake from the filter datapath.
// ----------------------------------------------------------------------------
module gtd_queue #(
  parameter int DATA_W = 17,
  parameter int DEPTH  = gtd_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] Full    = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/gtd_back.sv @@
// ----------------------------------------------------------------------------
// gtd_back
// Filter datapath: runs the recurrence on a shared 33x33 multiplier in split
// partial products, forms the bin outputs at block end and holds the result.
// ----------------------------------------------------------------------------
module gtd_back #(
  parameter int SAMPLE_BITS = gtd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gtd_pkg::cfg_t                    cfg_i,
  input  logic                             item_valid_i,
  output logic                             item_ready_o,
  input  logic [SAMPLE_BITS:0]             item_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [gtd_pkg::VAL_W-1:0] real_part_o,
  output logic signed [gtd_pkg::VAL_W-1:0] imaginary_part_o,
  output logic [gtd_pkg::POW_W-1:0]        power_o,
  output logic                             saturated_o
);
  import gtd_pkg::*;

  localparam int EXT_W = MUL_W - HALF_W;
  localparam int CEXT  = MUL_W - COEF_W;
  localparam int PEXT  = PROD_W - POW_W;

  back_state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic                          last_q, last_d;
  logic signed [PROD_W-1:0]      prod_q, acc_q, acc_d;
  logic signed [VAL_W-1:0]       recent_q, recent_d, older_q, older_d;
  logic signed [VAL_W-1:0]       re_q, re_d, im_q, im_d;
  logic [VAL_W-1:0]              ar_q, ar_d, ai_q, ai_d;
  logic [POW_W-1:0]              pow_q, pow_d;
  logic                          ovf_q, ovf_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0]       out_re_q, out_im_q;
  logic [POW_W-1:0]              out_pow_q;
  logic                          out_sat_q;
  logic                          out_load;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [MUL_W-1:0]  coef_x, cos_x, sin_x;
  logic signed [MUL_W-1:0]  rec_hi, rec_lo, old_hi, old_lo;
  logic signed [PROD_W-1:0] mul_p, acc_shift, acc_sum, pw_sum;
  logic signed [SUM_W-1:0]  rnd, v_sum, re_sum;
  clamp_t                   v_cl, re_cl, im_cl;
  logic                     root_big, pw_big;

  assign coef_x = {{CEXT{cfg_i.coef[COEF_W-1]}}, cfg_i.coef};
  assign cos_x  = {{CEXT{cfg_i.cosine[COEF_W-1]}}, cfg_i.cosine};
  assign sin_x  = {{CEXT{cfg_i.sine[COEF_W-1]}}, cfg_i.sine};
  assign rec_hi = {{EXT_W{recent_q[VAL_W-1]}}, recent_q[VAL_W-1:HALF_W]};
  assign rec_lo = {{EXT_W{1'b0}}, recent_q[HALF_W-1:0]};
  assign old_hi = {{EXT_W{older_q[VAL_W-1]}}, older_q[VAL_W-1:HALF_W]};
  assign old_lo = {{EXT_W{1'b0}}, older_q[HALF_W-1:0]};

  always_comb begin
    unique case (state_q)
      ST_RHI:   begin mul_a = coef_x; mul_b = rec_hi; end
      ST_RLO:   begin mul_a = coef_x; mul_b = rec_lo; end
      ST_CHI:   begin mul_a = cos_x;  mul_b = old_hi; end
      ST_CLO:   begin mul_a = cos_x;  mul_b = old_lo; end
      ST_CSUM:  begin mul_a = sin_x;  mul_b = old_hi; end
      ST_SLO:   begin mul_a = sin_x;  mul_b = old_lo; end
      ST_SQR_R: begin
        mul_a = {1'b0, ar_q[MUL_W-2:0]};
        mul_b = {1'b0, ar_q[MUL_W-2:0]};
      end
      ST_SQR_I: begin
        mul_a = {1'b0, ai_q[MUL_W-2:0]};
        mul_b = {1'b0, ai_q[MUL_W-2:0]};
      end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    acc_shift = prod_q <<< HALF_W;
    acc_sum   = acc_q + prod_q + ROUND_HALF;
    pw_sum    = acc_q + prod_q;
    rnd       = acc_q[FRAC_W+SUM_W-1:FRAC_W];
    v_sum     = SUM_W'(sample_q) + rnd - SUM_W'(older_q);
    re_sum    = SUM_W'(recent_q) - rnd;
    v_cl      = clamp_val(v_sum);
    re_cl     = clamp_val(re_sum);
    im_cl     = clamp_val(rnd);
    root_big  = (ar_q > ROOT_LIMIT) || (ai_q > ROOT_LIMIT);
    pw_big    = ($unsigned(pw_sum) > {{PEXT{1'b0}}, POWER_MAX});
    out_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  end

  assign item_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    sample_d    = sample_q;
    last_d      = last_q;
    acc_d       = acc_q;
    recent_d    = recent_q;
    older_d     = older_q;
    re_d        = re_q;
    im_d        = im_q;
    ar_d        = ar_q;
    ai_d        = ai_q;
    pow_d       = pow_q;
    ovf_d       = ovf_q;
    out_valid_d = out_load || (out_valid_q && out_stall_i);
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          sample_d = item_data_i[SAMPLE_BITS-1:0];
          last_d   = item_data_i[SAMPLE_BITS];
          state_d  = ST_RHI;
        end
      end
      ST_RHI: state_d = ST_RLO;
      ST_RLO: begin
        acc_d   = acc_shift;
        state_d = ST_RSUM;
      end
      ST_RSUM: begin
        acc_d   = acc_sum;
        state_d = ST_RUPD;
      end
      ST_RUPD: begin
        older_d  = recent_q;
        recent_d = v_cl.val;
        ovf_d    = ovf_q | v_cl.sat;
        state_d  = last_q ? ST_CHI : ST_IDLE;
      end
      ST_CHI: state_d = ST_CLO;
      ST_CLO: begin
        acc_d   = acc_shift;
        state_d = ST_CSUM;
      end
      ST_CSUM: begin
        acc_d   = acc_sum;
        state_d = ST_SLO;
      end
      ST_SLO: begin
        re_d    = re_cl.val;
        ovf_d   = ovf_q | re_cl.sat;
        acc_d   = acc_shift;
        state_d = ST_SSUM;
      end
      ST_SSUM: begin
        acc_d   = acc_sum;
        state_d = ST_IMAG;
      end
      ST_IMAG: begin
        im_d    = im_cl.val;
        ovf_d   = ovf_q | im_cl.sat;
        state_d = ST_MAG;
      end
      ST_MAG: begin
        ar_d    = re_q[VAL_W-1] ? $unsigned(-re_q) : $unsigned(re_q);
        ai_d    = im_q[VAL_W-1] ? $unsigned(-im_q) : $unsigned(im_q);
        state_d = ST_SQR_R;
      end
      ST_SQR_R: state_d = ST_SQR_I;
      ST_SQR_I: begin
        acc_d   = prod_q;
        state_d = ST_PSUM;
      end
      ST_PSUM: begin
        if (root_big || pw_big) begin
          pow_d = POWER_MAX;
          ovf_d = 1'b1;
        end else begin
          pow_d = pw_sum[POW_W-1:0];
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          recent_d = '0;
          older_d  = '0;
          ovf_d    = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      recent_q    <= '0;
      older_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      recent_q    <= recent_d;
      older_q     <= older_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    last_q   <= last_d;
    prod_q   <= mul_p;
    acc_q    <= acc_d;
    re_q     <= re_d;
    im_q     <= im_d;
    ar_q     <= ar_d;
    ai_q     <= ai_d;
    pow_q    <= pow_d;
    if (out_load) begin
      out_re_q  <= re_q;
      out_im_q  <= im_q;
      out_pow_q <= pow_q;
      out_sat_q <= ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign real_part_o      = out_re_q;
  assign imaginary_part_o = out_im_q;
  assign power_o          = out_pow_q;
  assign saturated_o      = out_sat_q;

endmodule

@@ rtl/goertzel_tone_detector.sv @@
// ----------------------------------------------------------------------------
// goertzel_tone_detector
// Single-bin Goertzel detector: sample intake, item queue, filter datapath and
// configuration registers.
// The back end takes a new sample only when it is idle again, as the shared
// multiplier forms the feedback product in two split partial products; a
// block's last sample also takes the output products and power before the
// result is loaded and out_valid_o rises.
// Reset clears filter state, count and queue, and loads the register
// defaults; no clearing pass.
// ----------------------------------------------------------------------------
module goertzel_tone_detector #(
  parameter int SAMPLE_BITS      = gtd_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_BLOCK_LENGTH = gtd_pkg::MAX_BLOCK_LENGTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [gtd_pkg::SAMPLE_W-1:0]   sample_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [gtd_pkg::VAL_W-1:0]      real_part_o,
  output logic signed [gtd_pkg::VAL_W-1:0]      imaginary_part_o,
  output logic [gtd_pkg::POW_W-1:0]             power_o,
  output logic                                  saturated_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [gtd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [gtd_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import gtd_pkg::*;

  localparam int ITEM_W = SAMPLE_BITS + 1;

  cfg_t              cfg_q, cfg_d;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  logic [ITEM_W-1:0] push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_COEF:      cfg_d.coef    = cfg_data_i;
        CFG_COSINE:    cfg_d.cosine  = cfg_data_i;
        CFG_SINE:      cfg_d.sine    = cfg_data_i;
        CFG_BLOCK_LEN: cfg_d.blk_len = cfg_data_i[LEN_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef    <= COEF_RESET;
      cfg_q.cosine  <= COSINE_RESET;
      cfg_q.sine    <= SINE_RESET;
      cfg_q.blk_len <= LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gtd_front #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .MAX_BLOCK_LENGTH (MAX_BLOCK_LENGTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_value_i (sample_value_i),
    .block_length_i (cfg_q.blk_len),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  gtd_queue #(
    .DATA_W (ITEM_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  gtd_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .item_valid_i     (pop_valid),
    .item_ready_o     (pop_ready),
    .item_data_i      (pop_data),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .real_part_o      (real_part_o),
    .imaginary_part_o (imaginary_part_o),
    .power_o          (power_o),
    .saturated_o      (saturated_o)
  );

endmodule

@@ dv/tb_goertzel_tone_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_goertzel_tone_detector
// Self-checking bench for the single-bin Goertzel detector. A bit-exact
// predictor tracks the filter pair, sample count and register settings, and
// turns each block-ending sample into the bin result it should cause. Results
// are checked in order against those predictions. Stimulus covers directed
// corner cases, a long resonant run under an over-range block length,
// mid-block length changes, a long output stall, and random register
// settings with random samples and random handshake gaps on both sides.
// ----------------------------------------------------------------------------
module tb_goertzel_tone_detector;

  localparam int          SETTLE_CYCLES  = 40;
  localparam int          RANDOM_SAMPLES = 1600;
  localparam int          LONG_RUN       = 200;
  localparam int          MAX_LEN        = gtd_pkg::MAX_BLOCK_LENGTH_DEF;
  localparam longint      CYCLE_LIMIT    = 3000000;
  localparam longint      VAL_HI         = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      VAL_LO         = -VAL_HI - 1;
  localparam longint unsigned ROOT_LIM   = 64'd3037000499;
  localparam longint unsigned POW_HI     = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [gtd_pkg::VAL_W-1:0] re;
    logic signed [gtd_pkg::VAL_W-1:0] im;
    logic [gtd_pkg::POW_W-1:0]        pw;
    logic                             sat;
  } bin_t;

  typedef struct {
    logic [gtd_pkg::CFG_IDX_W-1:0]  idx;
    logic [gtd_pkg::CFG_DATA_W-1:0] data;
  } reg_write_t;

  class bin_scoreboard;
    longint coef;
    longint cosine;
    longint sine;
    int     blk_len;
    longint recent;
    longint older;
    int     count;
    bit     ovf;
    bin_t   pending_bins[$];
    int     samples;
    int     checked;
    int     failures;
    int     writes;

    function new();
      coef     = 0;
      cosine   = 16384;
      sine     = 0;
      blk_len  = 256;
      recent   = 0;
      older    = 0;
      count    = 0;
      ovf      = 1'b0;
      samples  = 0;
      checked  = 0;
      failures = 0;
      writes   = 0;
    endfunction

    function longint round_q14(longint x);
      longint y;
      y = x + 8192;
      return y >>> 14;
    endfunction

    function longint clamp48(longint x, inout bit flag);
      if (x > VAL_HI) begin
        flag = 1'b1;
        return VAL_HI;
      end
      if (x < VAL_LO) begin
        flag = 1'b1;
        return VAL_LO;
      end
      return x;
    endfunction

    function void write_reg(logic [gtd_pkg::CFG_IDX_W-1:0] idx,
                            logic [gtd_pkg::CFG_DATA_W-1:0] data);
      writes++;
      case (idx)
        gtd_pkg::CFG_COEF:      coef    = longint'($signed(data));
        gtd_pkg::CFG_COSINE:    cosine  = longint'($signed(data));
        gtd_pkg::CFG_SINE:      sine    = longint'($signed(data));
        gtd_pkg::CFG_BLOCK_LEN: blk_len = int'(data[gtd_pkg::LEN_W-1:0]);
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [gtd_pkg::SAMPLE_W-1:0] smp);
      longint          v;
      longint          re;
      longint          im;
      longint unsigned ar;
      longint unsigned ai;
      longint unsigned pw;
      int              eff;
      bit              sat;
      bin_t            b;
      samples++;
      v = longint'(smp) + round_q14(coef * recent) - older;
      v = clamp48(v, ovf);
      older  = recent;
      recent = v;
      if (count < MAX_LEN) count++;
      eff = blk_len;
      if (eff < 1) eff = 1;
      if (eff > MAX_LEN) eff = MAX_LEN;
      if (count < eff) return;
      sat = ovf;
      re  = clamp48(recent - round_q14(older * cosine), sat);
      im  = clamp48(round_q14(older * sine), sat);
      ar  = (re < 0) ? -re : re;
      ai  = (im < 0) ? -im : im;
      if (ar > ROOT_LIM || ai > ROOT_LIM) begin
        pw  = POW_HI;
        sat = 1'b1;
      end else begin
        pw = ar * ar + ai * ai;
        if (pw > POW_HI) begin
          pw  = POW_HI;
          sat = 1'b1;
        end
      end
      b.re  = re[gtd_pkg::VAL_W-1:0];
      b.im  = im[gtd_pkg::VAL_W-1:0];
      b.pw  = pw[gtd_pkg::POW_W-1:0];
      b.sat = sat;
      pending_bins.push_back(b);
      recent = 0;
      older  = 0;
      count  = 0;
      ovf    = 1'b0;
    endfunction

    function void check_bin(logic signed [gtd_pkg::VAL_W-1:0] re,
                            logic signed [gtd_pkg::VAL_W-1:0] im,
                            logic [gtd_pkg::POW_W-1:0] pw, logic sat);
      bin_t e;
      if (pending_bins.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected bin: real %0d imag %0d power %0d sat %0b", re, im, pw, sat);
        return;
      end
      e = pending_bins.pop_front();
      checked++;
      if (re !== e.re || im !== e.im || pw !== e.pw || sat !== e.sat) begin
        failures++;
        if (failures <= 10) begin
          $display("bin %0d mismatch: exp real %0d imag %0d power %0d sat %0b",
                   checked, e.re, e.im, e.pw, e.sat);
          $display("                got real %0d imag %0d power %0d sat %0b",
                   re, im, pw, sat);
        end
      end
    endfunction
  endclass

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic signed [gtd_pkg::SAMPLE_W-1:0] sample_value_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic signed [gtd_pkg::VAL_W-1:0]    real_part_o;
  logic signed [gtd_pkg::VAL_W-1:0]    imaginary_part_o;
  logic [gtd_pkg::POW_W-1:0]           power_o;
  logic                                saturated_o;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [gtd_pkg::CFG_IDX_W-1:0]       cfg_index_i;
  logic [gtd_pkg::CFG_DATA_W-1:0]      cfg_data_i;

  bin_scoreboard sb = new();
  reg_write_t    reg_writes[$];
  bit            tx_eager;
  bit            rx_eager;
  int            long_hold;
  int            hold_reqs;
  longint        cycles = 0;

  goertzel_tone_detector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_value_i   (sample_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .real_part_o      (real_part_o),
    .imaginary_part_o (imaginary_part_o),
    .power_o          (power_o),
    .saturated_o      (saturated_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_sample(sample_value_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_bin(real_part_o, imaginary_part_o, power_o, saturated_o);
  end

  initial begin
    int n;
    int served;
    served      = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_reqs != served) begin
        n      = long_hold;
        served = hold_reqs;
      end else begin
        n = rx_eager ? 0 : $urandom_range(0, 19);
      end
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && hold_reqs == served);
    end
  end

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h4000;
      3:       return 16'hC000;
      4:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void stage_reg(logic [gtd_pkg::CFG_IDX_W-1:0] idx,
                                    logic [gtd_pkg::CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    reg_writes.push_back(w);
  endfunction

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending_bins.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic flush_regs();
    reg_write_t w;
    wait_idle();
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.idx;
      cfg_data_i  <= w.data;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(w.idx, w.data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(logic [15:0] s);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    int n;
    int sent_random;
    int len;
    logic [gtd_pkg::CFG_IDX_W-1:0] bad_idx;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    sample_value_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    tx_eager       = 1'b0;
    rx_eager       = 1'b0;
    long_hold      = 0;
    hold_reqs      = 0;
    sent_random    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero length acts as one: every sample is a block
    stage_reg(gtd_pkg::CFG_BLOCK_LEN, 16'h0000);
    flush_regs();
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);

    stage_reg(gtd_pkg::CFG_COEF, 16'h7FFF);
    stage_reg(gtd_pkg::CFG_COSINE, 16'h8000);
    stage_reg(gtd_pkg::CFG_SINE, 16'h7FFF);
    stage_reg(gtd_pkg::CFG_BLOCK_LEN, 16'hE003);
    flush_regs();
    repeat (3) send_sample(16'h7FFF);

    stage_reg(gtd_pkg::CFG_COEF, 16'h8000);
    stage_reg(gtd_pkg::CFG_COSINE, 16'h4000);
    stage_reg(gtd_pkg::CFG_SINE, 16'hC000);
    stage_reg(gtd_pkg::CFG_BLOCK_LEN, 16'h0002);
    flush_regs();
    repeat (4) send_sample(16'h8000);

    // shorten the block mid-way; ignore an out-of-range register
    stage_reg(gtd_pkg::CFG_BLOCK_LEN, 16'h0005);
    stage_reg(gtd_pkg::CFG_IDX_W'((1 << gtd_pkg::CFG_IDX_W) - 1), 16'hFFFF);
    flush_regs();
    repeat (3) send_sample(rand_sample());
    stage_reg(gtd_pkg::CFG_BLOCK_LEN, 16'h0002);
    flush_regs();
    send_sample(rand_sample());

    // hold the output long enough for the block to back up into its input
    stage_reg(gtd_pkg::CFG_BLOCK_LEN, 16'h0001);
    stage_reg(gtd_pkg::CFG_COEF, rand_coef());
    flush_regs();
    tx_eager  = 1'b1;
    long_hold = 600;
    hold_reqs++;
    repeat (40) send_sample(rand_sample());
    tx_eager = 1'b0;

    // long run at resonance under an over-range length, then cut short
    stage_reg(gtd_pkg::CFG_COEF, 16'h8000);
    stage_reg(gtd_pkg::CFG_COSINE, 16'h4000);
    stage_reg(gtd_pkg::CFG_SINE, 16'h0000);
    stage_reg(gtd_pkg::CFG_BLOCK_LEN, 16'h1FFF);
    flush_regs();
    tx_eager = 1'b1;
    rx_eager = 1'b1;
    for (int i = 0; i < LONG_RUN; i++) send_sample(i[0] ? 16'h8000 : 16'h7FFF);
    stage_reg(gtd_pkg::CFG_BLOCK_LEN, 16'h1000);
    flush_regs();
    repeat (30) send_sample(rand_sample());
    stage_reg(gtd_pkg::CFG_BLOCK_LEN, 16'h0001);
    flush_regs();
    send_sample(rand_sample());
    tx_eager = 1'b0;
    rx_eager = 1'b0;

    while (sent_random < RANDOM_SAMPLES) begin
      if ($urandom_range(0, 2) == 0) stage_reg(gtd_pkg::CFG_COEF, rand_coef());
      if ($urandom_range(0, 2) == 0) stage_reg(gtd_pkg::CFG_COSINE, rand_coef());
      if ($urandom_range(0, 2) == 0) stage_reg(gtd_pkg::CFG_SINE, rand_coef());
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 15))
          0:       len = 0;
          1, 2:    len = $urandom_range(17, 64);
          default: len = $urandom_range(1, 8);
        endcase
        stage_reg(gtd_pkg::CFG_BLOCK_LEN, {3'($urandom), 13'(len)});
      end
      if ($urandom_range(0, 7) == 0) begin
        bad_idx = gtd_pkg::CFG_IDX_W'($urandom_range(int'(gtd_pkg::CFG_BLOCK_LEN) + 1,
                                                     (1 << gtd_pkg::CFG_IDX_W) - 1));
        stage_reg(bad_idx, 16'($urandom));
      end
      flush_regs();
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 60);
      repeat (n) send_sample(rand_sample());
      sent_random += n;
    end

    wait_idle();
    $display("checked %0d bins from %0d samples across %0d register writes",
             sb.checked, sb.samples, sb.writes);
    $display("run had a resonant over-range block, mid-block length cuts and a long stall");
    if (sb.failures == 0 && sb.pending_bins.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures, %0d bins outstanding", sb.failures, sb.pending_bins.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
